// ===== rtl/ttmc_pkg.sv =====
package ttmc_pkg;

  // Burst and filter constants
  localparam logic [3:0] BURST_LEN  = 4'd10;
  localparam int         TRIM_SHIFT = 3;
  localparam int         FRAC_BITS  = 16;

  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 16;
  localparam int FILT_W   = SUM_W - TRIM_SHIFT;   // filtered axis width
  localparam int COEF_W   = 32;
  localparam int PROD_W   = FILT_W + 1 + COEF_W;  // signed product width
  localparam int ACC_W    = PROD_W + 2;           // two products plus offset
  localparam int COORD_W  = 16;
  localparam int IDX_W    = 3;

  // Register map
  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_XX  = 3'd0,
    REG_GAIN_XY  = 3'd1,
    REG_OFFSET_X = 3'd2,
    REG_GAIN_YX  = 3'd3,
    REG_GAIN_YY  = 3'd4,
    REG_OFFSET_Y = 3'd5
  } cfg_reg_t;

  // Reset values of the calibration registers (Q16.16)
  localparam logic [COEF_W-1:0] RST_GAIN_XX  = 32'sd5881;
  localparam logic [COEF_W-1:0] RST_GAIN_XY  = -32'sd19;
  localparam logic [COEF_W-1:0] RST_OFFSET_X = -32'sd1350842;
  localparam logic [COEF_W-1:0] RST_GAIN_YX  = -32'sd90;
  localparam logic [COEF_W-1:0] RST_GAIN_YY  = 32'sd4224;
  localparam logic [COEF_W-1:0] RST_OFFSET_Y = -32'sd1052115;

  // Status codes
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_ABORT = 1'b1;

  // Job passed from front to back
  typedef struct packed {
    logic              abort;
    logic [FILT_W-1:0] fx;
    logic [FILT_W-1:0] fy;
  } job_t;

  // Calibration coefficients
  typedef struct packed {
    logic [COEF_W-1:0] gain_xx;
    logic [COEF_W-1:0] gain_xy;
    logic [COEF_W-1:0] offset_x;
    logic [COEF_W-1:0] gain_yx;
    logic [COEF_W-1:0] gain_yy;
    logic [COEF_W-1:0] offset_y;
  } coef_t;

  // Divide by 2^FRAC_BITS truncating toward zero, then clamp to signed 16 bits
  function automatic logic [COORD_W-1:0] trunc_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-FRAC_BITS:0] q;
    logic                            adj;
    adj = acc[ACC_W-1] && (acc[FRAC_BITS-1:0] != '0);
    q   = $signed({acc[ACC_W-1], acc[ACC_W-1:FRAC_BITS]})
          + $signed({{(ACC_W-FRAC_BITS){1'b0}}, adj});
    if (q > $signed((ACC_W-FRAC_BITS+1)'(32767))) begin
      trunc_sat = 16'h7FFF;
    end else if (q < -$signed((ACC_W-FRAC_BITS+1)'(32768))) begin
      trunc_sat = 16'h8000;
    end else begin
      trunc_sat = q[COORD_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/ttmc_front.sv =====
module ttmc_front
  import ttmc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [SAMPLE_W-1:0] x_sample,
  input  logic [SAMPLE_W-1:0] y_sample,
  input  logic                pen_down,
  output logic                push,
  output job_t                job
);

  logic [3:0]          count_r, count_nxt;
  logic [SUM_W-1:0]    x_sum_r, x_sum_nxt, y_sum_r, y_sum_nxt;
  logic [SAMPLE_W-1:0] x_min_r, x_min_nxt, x_max_r, x_max_nxt;
  logic [SAMPLE_W-1:0] y_min_r, y_min_nxt, y_max_r, y_max_nxt;
  logic [3:0]          count_inc;
  logic [SUM_W-1:0]    x_trim, y_trim;
  logic                done;

  // Running min/max, reloaded by the first sample of a burst
  always_comb begin
    if (count_r == '0) begin
      x_min_nxt = x_sample;
      x_max_nxt = x_sample;
      y_min_nxt = y_sample;
      y_max_nxt = y_sample;
    end else begin
      x_min_nxt = (x_sample < x_min_r) ? x_sample : x_min_r;
      x_max_nxt = (x_sample > x_max_r) ? x_sample : x_max_r;
      y_min_nxt = (y_sample < y_min_r) ? y_sample : y_min_r;
      y_max_nxt = (y_sample > y_max_r) ? y_sample : y_max_r;
    end
  end

  // Sums, count and trimmed mean
  assign count_inc = count_r + 4'd1;
  assign done      = (count_inc >= BURST_LEN);
  assign x_trim    = x_sum_r + SUM_W'(x_sample) - SUM_W'(x_min_nxt) - SUM_W'(x_max_nxt);
  assign y_trim    = y_sum_r + SUM_W'(y_sample) - SUM_W'(y_min_nxt) - SUM_W'(y_max_nxt);

  always_comb begin
    count_nxt = count_inc;
    x_sum_nxt = x_sum_r + SUM_W'(x_sample);
    y_sum_nxt = y_sum_r + SUM_W'(y_sample);
    if (done || !pen_down) begin
      count_nxt = '0;
      x_sum_nxt = '0;
      y_sum_nxt = '0;
    end
  end

  assign push      = take && (done || !pen_down);
  assign job.abort = !done;
  assign job.fx    = x_trim[SUM_W-1:TRIM_SHIFT];
  assign job.fy    = y_trim[SUM_W-1:TRIM_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      x_sum_r <= '0;
      y_sum_r <= '0;
    end else if (take) begin
      count_r <= count_nxt;
      x_sum_r <= x_sum_nxt;
      y_sum_r <= y_sum_nxt;
    end
  end

  // Min/max payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      x_min_r <= x_min_nxt;
      x_max_r <= x_max_nxt;
      y_min_r <= y_min_nxt;
      y_max_r <= y_max_nxt;
    end
  end

endmodule

// ===== rtl/ttmc_queue.sv =====
module ttmc_queue
  import ttmc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_job   = mem[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue pop while empty");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count did not follow push");

endmodule

// ===== rtl/ttmc_back.sv =====
module ttmc_back
  import ttmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  coef_t              coef,
  input  logic               job_valid,
  input  job_t               job,
  output logic               job_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] x_coord,
  output logic [COORD_W-1:0] y_coord,
  output logic               status
);

  logic                     adv;
  logic                     a_valid_r, a_abort_r, b_valid_r, b_abort_r, out_valid_r;
  logic signed [PROD_W-1:0] pxx_r, pxy_r, pyx_r, pyy_r;
  logic signed [ACC_W-1:0]  accx_r, accy_r;
  logic signed [FILT_W:0]   fx_s, fy_s;
  logic [COORD_W-1:0]       x_coord_r, y_coord_r;
  logic                     status_r;

  // Whole pipe moves when the output slot is free or being emptied
  assign adv     = !out_valid_r || out_ready;
  assign job_pop = adv && job_valid;
  assign fx_s    = $signed({1'b0, job.fx});
  assign fy_s    = $signed({1'b0, job.fy});

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= job_valid;
      b_valid_r   <= a_valid_r;
      out_valid_r <= b_valid_r;
    end
  end

  // Stage A: four products; B: sums with offset; C: truncate and clamp
  always_ff @(posedge clk) begin
    if (adv) begin
      a_abort_r <= job.abort;
      pxx_r     <= fx_s * $signed(coef.gain_xx);
      pxy_r     <= fy_s * $signed(coef.gain_xy);
      pyx_r     <= fx_s * $signed(coef.gain_yx);
      pyy_r     <= fy_s * $signed(coef.gain_yy);
      b_abort_r <= a_abort_r;
      accx_r    <= {{2{pxx_r[PROD_W-1]}}, pxx_r} + {{2{pxy_r[PROD_W-1]}}, pxy_r}
                   + {{(ACC_W-COEF_W){coef.offset_x[COEF_W-1]}}, coef.offset_x};
      accy_r    <= {{2{pyx_r[PROD_W-1]}}, pyx_r} + {{2{pyy_r[PROD_W-1]}}, pyy_r}
                   + {{(ACC_W-COEF_W){coef.offset_y[COEF_W-1]}}, coef.offset_y};
      x_coord_r <= b_abort_r ? '0 : trunc_sat(accx_r);
      y_coord_r <= b_abort_r ? '0 : trunc_sat(accy_r);
      status_r  <= b_abort_r ? STAT_ABORT : STAT_OK;
    end
  end

  assign out_valid = out_valid_r;
  assign x_coord   = x_coord_r;
  assign y_coord   = y_coord_r;
  assign status    = status_r;

  a_abort_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == STAT_ABORT) |-> (x_coord_r == '0 && y_coord_r == '0))
    else $error("aborted item carries nonzero coordinates");

  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> a_valid_r)
    else $error("popped job did not enter stage A");

  a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && b_valid_r) |=> out_valid_r)
    else $error("stage B item lost");

endmodule

// ===== rtl/touch_trimmed_mean_calibrate_unit.sv =====
// Channel | Ports                                           | Handshake
// in      | in_x_sample, in_y_sample, in_pen_down           | in_valid / in_ready
// out     | out_x_coord, out_y_coord, out_status            | out_valid / out_ready
// cfg     | cfg_index, cfg_wdata                            | cfg_we, no wait
//
// One item per cycle sustained while the job queue is not full. The front updates
// count, sums and min/max; a burst's last sample goes into the job queue, which
// feeds the back, a three-stage multiply / add / truncate-and-clamp pipe (A, B, C).
// in_ready drops only when the job queue is full; the back stalls on out_ready alone.
// Synchronous active-low reset clears burst state, queue and pipe valids, and
// reloads the default coefficients.
module touch_trimmed_mean_calibrate_unit
  import ttmc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_x_sample,
  input  logic [SAMPLE_W-1:0] in_y_sample,
  input  logic                in_pen_down,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COORD_W-1:0]  out_x_coord,
  output logic [COORD_W-1:0]  out_y_coord,
  output logic                out_status,
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [COEF_W-1:0]   cfg_wdata
);

  coef_t coef_r;
  logic  take, push, full, job_valid, job_pop;
  job_t  push_job, pop_job;

  // Calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.gain_xx  <= RST_GAIN_XX;
      coef_r.gain_xy  <= RST_GAIN_XY;
      coef_r.offset_x <= RST_OFFSET_X;
      coef_r.gain_yx  <= RST_GAIN_YX;
      coef_r.gain_yy  <= RST_GAIN_YY;
      coef_r.offset_y <= RST_OFFSET_Y;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAIN_XX:  coef_r.gain_xx  <= cfg_wdata;
        REG_GAIN_XY:  coef_r.gain_xy  <= cfg_wdata;
        REG_OFFSET_X: coef_r.offset_x <= cfg_wdata;
        REG_GAIN_YX:  coef_r.gain_yx  <= cfg_wdata;
        REG_GAIN_YY:  coef_r.gain_yy  <= cfg_wdata;
        REG_OFFSET_Y: coef_r.offset_y <= cfg_wdata;
        default:      coef_r          <= coef_r;
      endcase
    end
  end

  assign in_ready = !full;
  assign take     = in_valid && in_ready;

  ttmc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .x_sample (in_x_sample),
    .y_sample (in_y_sample),
    .pen_down (in_pen_down),
    .push     (push),
    .job      (push_job)
  );

  ttmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop       (job_pop),
    .not_empty (job_valid),
    .pop_job   (pop_job)
  );

  ttmc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef_r),
    .job_valid (job_valid),
    .job       (pop_job),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .x_coord   (out_x_coord),
    .y_coord   (out_y_coord),
    .status    (out_status)
  );

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ttmc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PCT     = 7;
  localparam int PHASE_ITEMS  = 120;
  localparam int REPORT_MAX   = 10;

  localparam logic [SAMPLE_W-1:0] ADC_MAX = '1;
  // Indexes past the register map; writes there must be dropped
  localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               status;
  } point_t;

  // Burst filter and calibration predictor plus in-order point checker
  class point_scoreboard;
    logic signed [COEF_W-1:0] coef [6];
    logic [3:0]               count;
    logic [SUM_W-1:0]         x_sum, y_sum;
    logic [SAMPLE_W-1:0]      x_lo, x_hi, y_lo, y_hi;
    point_t                   pending_points [$];
    int                       mismatches, points_seen, aborts_seen, samples_seen;

    function new();
      coef[REG_GAIN_XX]  = RST_GAIN_XX;
      coef[REG_GAIN_XY]  = RST_GAIN_XY;
      coef[REG_OFFSET_X] = RST_OFFSET_X;
      coef[REG_GAIN_YX]  = RST_GAIN_YX;
      coef[REG_GAIN_YY]  = RST_GAIN_YY;
      coef[REG_OFFSET_Y] = RST_OFFSET_Y;
      count = '0;
      x_sum = '0;
      y_sum = '0;
      mismatches = 0;
      points_seen = 0;
      aborts_seen = 0;
      samples_seen = 0;
    endfunction

    function void set_coef(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] val);
      if (idx <= REG_OFFSET_Y) begin
        coef[idx] = val;
      end
    endfunction

    // (ga*fx + gb*fy + off) / 2^16, truncated toward zero, clamped to 16 bits
    function logic [COORD_W-1:0] calibrate_axis(logic signed [COEF_W-1:0] ga,
                                                logic signed [COEF_W-1:0] gb,
                                                logic signed [COEF_W-1:0] off,
                                                logic [FILT_W-1:0] fx,
                                                logic [FILT_W-1:0] fy);
      longint acc, q;
      acc = longint'(ga) * longint'(fx) + longint'(gb) * longint'(fy) + longint'(off);
      q = acc / 65536;
      if (q > 32767) begin
        q = 32767;
      end else if (q < -32768) begin
        q = -32768;
      end
      return q[COORD_W-1:0];
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] xs, logic [SAMPLE_W-1:0] ys,
                              logic pen);
      logic [SUM_W-1:0]  tx, ty;
      logic [FILT_W-1:0] fx, fy;
      point_t            p;
      samples_seen++;
      // first sample of a burst seeds min/max
      if (count == 0) begin
        x_lo = xs; x_hi = xs;
        y_lo = ys; y_hi = ys;
      end else begin
        if (xs < x_lo) x_lo = xs; else if (xs > x_hi) x_hi = xs;
        if (ys < y_lo) y_lo = ys; else if (ys > y_hi) y_hi = ys;
      end
      x_sum = x_sum + xs;
      y_sum = y_sum + ys;
      count = count + 1'b1;
      if (count >= BURST_LEN) begin
        // trimmed mean: drop min and max, divide by 8
        tx = x_sum - x_lo - x_hi;
        ty = y_sum - y_lo - y_hi;
        fx = tx[SUM_W-1:TRIM_SHIFT];
        fy = ty[SUM_W-1:TRIM_SHIFT];
        p.x = calibrate_axis(coef[REG_GAIN_XX], coef[REG_GAIN_XY], coef[REG_OFFSET_X],
                             fx, fy);
        p.y = calibrate_axis(coef[REG_GAIN_YX], coef[REG_GAIN_YY], coef[REG_OFFSET_Y],
                             fx, fy);
        p.status = STAT_OK;
        pending_points.push_back(p);
        count = '0; x_sum = '0; y_sum = '0;
      end else if (!pen) begin
        // pen lifted early: abort marker, burst restarts
        p.x = '0;
        p.y = '0;
        p.status = STAT_ABORT;
        pending_points.push_back(p);
        count = '0; x_sum = '0; y_sum = '0;
      end
    endfunction

    function void check_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic st);
      point_t want;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: unexpected point x=%0d y=%0d status=%0d",
                   $signed(x), $signed(y), st);
        return;
      end
      want = pending_points.pop_front();
      if (want.status == STAT_ABORT) aborts_seen++; else points_seen++;
      if (want.x !== x || want.y !== y || want.status !== st) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: point mismatch exp x=%0d y=%0d status=%0d, got x=%0d y=%0d status=%0d",
                   $signed(want.x), $signed(want.y), want.status,
                   $signed(x), $signed(y), st);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_x_sample = '0;
  logic [SAMPLE_W-1:0] in_y_sample = '0;
  logic                in_pen_down = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [COORD_W-1:0]  out_x_coord;
  logic [COORD_W-1:0]  out_y_coord;
  logic                out_status;
  logic                cfg_we = 1'b0;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [COEF_W-1:0]   cfg_wdata = '0;

  point_scoreboard sb;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int stall_cycles = 0;
  int settings_run = 0;

  touch_trimmed_mean_calibrate_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_x_sample (in_x_sample),
    .in_y_sample (in_y_sample),
    .in_pen_down (in_pen_down),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x_coord (out_x_coord),
    .out_y_coord (out_y_coord),
    .out_status  (out_status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Monitor: check results first, then predict from the accepted sample
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_point(out_x_coord, out_y_coord, out_status);
      if (in_valid && in_ready) sb.note_sample(in_x_sample, in_y_sample, in_pen_down);
      if (in_valid && !in_ready) stall_cycles++;
    end
  end

  // Result side: random back-pressure plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one sample; entered and left at a falling edge
  task automatic send_sample(logic [SAMPLE_W-1:0] xs, logic [SAMPLE_W-1:0] ys,
                             logic pen);
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_x_sample <= xs;
    in_y_sample <= ys;
    in_pen_down <= pen;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_coef(idx, val);
    @(negedge clk);
  endtask

  task automatic write_coefs(logic [COEF_W-1:0] gxx, logic [COEF_W-1:0] gxy,
                             logic [COEF_W-1:0] ox, logic [COEF_W-1:0] gyx,
                             logic [COEF_W-1:0] gyy, logic [COEF_W-1:0] oy);
    write_reg(REG_GAIN_XX, gxx);
    write_reg(REG_GAIN_XY, gxy);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_GAIN_YX, gyx);
    write_reg(REG_GAIN_YY, gyy);
    write_reg(REG_OFFSET_Y, oy);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Wait out every expected point, then the pipe latency
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_points.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] jitter(int center, int spread);
    int v;
    if (spread >= 4096) return SAMPLE_W'($urandom_range(4095));
    v = center + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic [COEF_W-1:0] moderate_gain();
    return COEF_W'(int'($urandom_range(1 << 21)) - (1 << 20));
  endfunction

  task automatic directed_samples();
    // alternating rails: both extremes get trimmed away
    for (int i = 0; i < 10; i++)
      send_sample(i[0] ? ADC_MAX : '0, i[0] ? '0 : ADC_MAX, 1'b1);
    // full scale, pen lifted on the tenth sample: still a valid point
    for (int i = 0; i < 10; i++)
      send_sample(ADC_MAX, ADC_MAX, i != 9);
    // lift on the very first sample
    send_sample(ADC_MAX, '0, 1'b0);
    // lift on the third sample
    send_sample(12'h555, 12'hAAA, 1'b1);
    send_sample(12'hAAA, 12'h555, 1'b1);
    send_sample('0, ADC_MAX, 1'b0);
  endtask

  // Mostly complete bursts, some early lifts, a few noisy sequences
  task automatic random_bursts(int n_items);
    int sent, kind, len, cx, cy, spread;
    logic pen;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 75) len = 10;
      else if (kind < 92) len = $urandom_range(1, 9);
      else len = $urandom_range(1, 12);
      cx = $urandom_range(4095);
      cy = $urandom_range(4095);
      case ($urandom_range(3))
        0: spread = 4;
        1: spread = 40;
        2: spread = 400;
        default: spread = 4096;
      endcase
      for (int i = 1; i <= len; i++) begin
        if (kind >= 92) pen = $urandom_range(1);
        else if (i == 10) pen = $urandom_range(1);
        else pen = (i != len);
        send_sample(jitter(cx, spread), jitter(cy, spread), pen);
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset coefficients
    settings_run++;
    directed_samples();
    random_bursts(PHASE_ITEMS);
    drain();

    // all registers at the positive extreme
    write_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    random_bursts(PHASE_ITEMS);
    drain();

    // negative extreme, no idling on either side
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    random_bursts(PHASE_ITEMS);
    drain();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    // moderate random gains; result side holds off long enough to fill the queue
    write_coefs(moderate_gain(), moderate_gain(), COEF_W'($urandom) >>> 3,
                moderate_gain(), moderate_gain(), COEF_W'($urandom) >>> 3);
    hold_request = 1'b1;
    random_bursts(PHASE_ITEMS);
    drain();

    // writes past the map must be ignored; then zero gains, full-range offsets
    write_reg(REG_SPARE_6, COEF_W'($urandom));
    write_reg(REG_SPARE_7, COEF_W'($urandom));
    write_coefs('0, '0, COEF_W'($urandom), '0, '0, COEF_W'($urandom));
    random_bursts(PHASE_ITEMS);
    drain();

    // gain of 8 on the diagonal, small cross terms
    write_coefs(32'sd524288, moderate_gain() >>> 4, -32'sd65536 * 100,
                moderate_gain() >>> 4, 32'sd524288, 32'sd65536 * 100);
    random_bursts(PHASE_ITEMS);
    drain();

    // back to the power-on calibration
    write_coefs(RST_GAIN_XX, RST_GAIN_XY, RST_OFFSET_X,
                RST_GAIN_YX, RST_GAIN_YY, RST_OFFSET_Y);
    random_bursts(PHASE_ITEMS);
    drain();

    if (sb.pending_points.size() != 0) begin
      $display("ERROR: %0d points never arrived", sb.pending_points.size());
      sb.mismatches += sb.pending_points.size();
    end
    $display("Ran %0d samples over %0d calibration settings: %0d points, %0d early lifts",
             sb.samples_seen, settings_run, sb.points_seen, sb.aborts_seen);
    $display("Input back-pressured for %0d cycles, %0d mismatches",
             stall_cycles, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== touch_trimmed_mean_calibrate_unit.f =====
rtl/ttmc_pkg.sv
rtl/ttmc_front.sv
rtl/ttmc_queue.sv
rtl/ttmc_back.sv
rtl/touch_trimmed_mean_calibrate_unit.sv
bench/testbench.sv
